/* rtl/two_level_feedback_queue_scheduler_unit_defines.svh */
// assertion helpers for the scheduler
`ifndef TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define TLFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlfq_pkg.sv */
package tlfq_pkg;

    localparam int MAX_PROCS = 16;
    localparam int PTR_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic LEVEL_ONE = 1'b0;
    localparam logic LEVEL_TWO = 1'b1;

    localparam logic [15:0] SLICE_RESET = 16'd4;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_FULL     = 3'd1,
        ST_RAN      = 3'd2,
        ST_DONE     = 3'd3,
        ST_IDLE     = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] left;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t entry;
    } fifo_ctl_t;

    // wrap a pointer sum that stays below twice the depth
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [CNT_W:0] sum);
        logic [CNT_W:0] w;
        begin
            if (sum >= (CNT_W+1)'(MAX_PROCS))
            begin
                w = sum - (CNT_W+1)'(MAX_PROCS);
            end
            else
            begin
                w = sum;
            end
            return w[PTR_W-1:0];
        end
    endfunction

endpackage

/* rtl/tlfq_fifo.sv */
module tlfq_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tlfq_pkg::fifo_ctl_t         ctl,
    output tlfq_pkg::entry_t            head_entry,
    output logic [tlfq_pkg::CNT_W-1:0]  count
);

    tlfq_pkg::entry_t                  mem [tlfq_pkg::MAX_PROCS];
    logic [tlfq_pkg::PTR_W-1:0]        head_reg;
    logic [tlfq_pkg::PTR_W-1:0]        head_next;
    logic [tlfq_pkg::CNT_W-1:0]        count_reg;
    logic [tlfq_pkg::CNT_W-1:0]        count_next;
    logic [tlfq_pkg::PTR_W-1:0]        tail;

    assign tail = tlfq_pkg::wrap_ptr({1'b0, {(tlfq_pkg::CNT_W-tlfq_pkg::PTR_W){1'b0}}, head_reg}
                                     + {1'b0, count_reg});

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next = tlfq_pkg::wrap_ptr(
                {1'b0, {(tlfq_pkg::CNT_W-tlfq_pkg::PTR_W){1'b0}}, head_reg}
                + (tlfq_pkg::CNT_W+1)'(1));
        end
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + tlfq_pkg::CNT_W'(1);
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - tlfq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail] <= ctl.entry;
        end
    end

    assign head_entry = mem[head_reg];
    assign count      = count_reg;

endmodule

/* rtl/two_level_feedback_queue_scheduler_unit.sv */
// channel  | direction | handshake             | payload
// cfg      | in        | cfg_valid / cfg_ready | cfg_data (time slice)
// in       | in        | in_valid / in_ready   | cmd, proc_id, burst_len
// out      | out       | out_valid / out_ready | status, served_id, served_level,
//          |           |                       | slice_used, time_left, clock_now
//
// one beat per cycle sustained unless the output stalls; each beat is held in
// the input register, which feeds single-pass queue logic whose state updates
// as the result register loads, so the next command sees it at once
// a stalled output holds one result while the input register keeps one more
// reset empties both queues, clears the clock and sets the time slice to 4
`include "two_level_feedback_queue_scheduler_unit_defines.svh"

module two_level_feedback_queue_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [15:0] proc_id,
    input  logic [15:0] burst_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] served_id,
    output logic        served_level,
    output logic [15:0] slice_used,
    output logic [15:0] time_left,
    output logic [31:0] clock_now
);

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [15:0] s1_id_reg;
    logic [15:0] s1_burst_reg;
    logic        s1_adv;

    logic [15:0] slice_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;

    logic              out_valid_reg;
    tlfq_pkg::status_t status_reg;
    tlfq_pkg::status_t status_next;
    logic [15:0]       id_reg;
    logic [15:0]       id_next;
    logic              level_reg;
    logic              level_next;
    logic [15:0]       used_reg;
    logic [15:0]       used_next;
    logic [15:0]       left_reg;
    logic [15:0]       left_next;

    tlfq_pkg::fifo_ctl_t          l1_ctl;
    tlfq_pkg::fifo_ctl_t          l2_ctl;
    tlfq_pkg::entry_t             l1_head;
    tlfq_pkg::entry_t             l2_head;
    logic [tlfq_pkg::CNT_W-1:0]   l1_count;
    logic [tlfq_pkg::CNT_W-1:0]   l2_count;
    logic [tlfq_pkg::CNT_W:0]     total;
    logic                         full;

    tlfq_pkg::entry_t served;
    logic [15:0]      quantum;
    logic [15:0]      used;
    logic [15:0]      remain;
    logic [32:0]      clock_sum;

    logic                         slots_ok;
    logic                         idle_dispatch;
    logic                         is_idle;
    logic                         enq_accept;
    logic [tlfq_pkg::CNT_W-1:0]   l1_inc;

    tlfq_fifo u_level_one (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (l1_ctl),
        .head_entry (l1_head),
        .count      (l1_count)
    );

    tlfq_fifo u_level_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (l2_ctl),
        .head_entry (l2_head),
        .count      (l2_count)
    );

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign cfg_ready = 1'b1;

    assign total   = {1'b0, l1_count} + {1'b0, l2_count};
    assign full    = total >= (tlfq_pkg::CNT_W+1)'(tlfq_pkg::MAX_PROCS);
    assign served  = (l1_count != '0) ? l1_head : l2_head;
    assign quantum = (slice_reg == 16'd0) ? 16'd1 : slice_reg;
    assign used    = (quantum < served.left) ? quantum : served.left;
    assign remain  = served.left - used;
    assign clock_sum = {1'b0, elapsed_reg} + {17'd0, used};

    always_comb
    begin
        l1_ctl       = '0;
        l2_ctl       = '0;
        status_next  = tlfq_pkg::ST_IDLE;
        id_next      = 16'd0;
        level_next   = tlfq_pkg::LEVEL_ONE;
        used_next    = 16'd0;
        left_next    = 16'd0;
        elapsed_next = elapsed_reg;
        case (s1_cmd_reg)
            tlfq_pkg::CMD_ENQUEUE:
            begin
                l1_ctl.entry = '{id: s1_id_reg, left: s1_burst_reg};
                if (full)
                begin
                    status_next = tlfq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = tlfq_pkg::ST_ENQUEUED;
                    l1_ctl.push = s1_adv;
                end
            end
            tlfq_pkg::CMD_DISPATCH:
            begin
                l2_ctl.entry = '{id: served.id, left: remain};
                if (l1_count != '0 || l2_count != '0)
                begin
                    id_next      = served.id;
                    used_next    = used;
                    left_next    = remain;
                    elapsed_next = clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];
                    if (l1_count != '0)
                    begin
                        level_next = tlfq_pkg::LEVEL_ONE;
                        l1_ctl.pop = s1_adv;
                    end
                    else
                    begin
                        level_next = tlfq_pkg::LEVEL_TWO;
                        l2_ctl.pop = s1_adv;
                    end
                    if (remain == 16'd0)
                    begin
                        status_next = tlfq_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = tlfq_pkg::ST_RAN;
                        l2_ctl.push = s1_adv;
                    end
                end
            end
            default:
            begin
                status_next = tlfq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            slice_reg     <= tlfq_pkg::SLICE_RESET;
            elapsed_reg   <= 32'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                elapsed_reg   <= elapsed_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                slice_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg   <= cmd;
            s1_id_reg    <= proc_id;
            s1_burst_reg <= burst_len;
        end
        if (s1_adv)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            level_reg  <= level_next;
            used_reg   <= used_next;
            left_reg   <= left_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = id_reg;
    assign served_level = level_reg;
    assign slice_used   = used_reg;
    assign time_left    = left_reg;
    assign clock_now    = elapsed_reg;

    assign slots_ok      = total <= (tlfq_pkg::CNT_W+1)'(tlfq_pkg::MAX_PROCS);
    assign idle_dispatch = s1_adv && s1_cmd_reg == tlfq_pkg::CMD_DISPATCH
                           && l1_count == '0 && l2_count == '0;
    assign is_idle       = status_reg == tlfq_pkg::ST_IDLE;
    assign enq_accept    = s1_adv && s1_cmd_reg == tlfq_pkg::CMD_ENQUEUE && !full;
    assign l1_inc        = l1_count + tlfq_pkg::CNT_W'(1);

    `TLFQ_ASSERT_NOW(a_shared_slots, 1'b1, slots_ok, "slots oversubscribed")
    `TLFQ_ASSERT_NOW(a_ready_when_drained, !out_valid_reg, in_ready, "input stalled when drained")
    `TLFQ_ASSERT_NEXT(a_idle_report, idle_dispatch, is_idle && $stable(elapsed_reg), "idle missed")
    `TLFQ_ASSERT_NEXT(a_enqueue_count, enq_accept, l1_count == $past(l1_inc), "enqueue lost")

endmodule
